/* rtl/grid_line_tile_walker_defines.svh */
// Assertion macros shared by the grid line tile walker RTL.
`ifndef GRID_LINE_TILE_WALKER_DEFINES_SVH
`define GRID_LINE_TILE_WALKER_DEFINES_SVH
`ifndef SYNTH
// Check a property on every rising edge, held off while reset is high.
`define GLW_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define GLW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GLW_ASSERT(lbl, clk, rst, prop, msg)
`define GLW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/glw_pkg.sv */
// Shared widths, state encoding and control structs of the tile walker.
package glw_pkg;

  localparam int PX_W   = 10;  // pixel coordinate
  localparam int TILE_W = 5;   // tile coordinate
  localparam int DBL_W  = 6;   // doubled tile difference
  localparam int ERR_W  = 7;   // signed error term, -62..62
  localparam int CNT_W  = 6;   // tiles still to emit, up to 63

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_WALK
  } glw_state_t;

  typedef struct packed {
    logic load;   // capture a request and set up the walk
    logic step;   // current tile taken, advance to the next one
  } glw_cmd_t;

  typedef struct packed {
    logic last;   // current tile is the final one of the walk
  } glw_sts_t;

endpackage

/* rtl/glw_req_if.sv */
// Request channel: start and end point of one walk in pixels.
interface glw_req_if;
  import glw_pkg::*;

  logic            valid;
  logic            ready;
  logic [PX_W-1:0] start_px_x;
  logic [PX_W-1:0] start_px_y;
  logic [PX_W-1:0] end_px_x;
  logic [PX_W-1:0] end_px_y;

  modport source (output valid, start_px_x, start_px_y, end_px_x, end_px_y, input ready);
  modport sink   (input valid, start_px_x, start_px_y, end_px_x, end_px_y, output ready);
endinterface

/* rtl/glw_tile_if.sv */
// Tile channel: one visited tile of a walk per item.
interface glw_tile_if;
  import glw_pkg::*;

  logic              valid;
  logic              ready;
  logic [TILE_W-1:0] tile_x;
  logic [TILE_W-1:0] tile_y;
  logic              last_tile;

  modport source (output valid, tile_x, tile_y, last_tile, input ready);
  modport sink   (input valid, tile_x, tile_y, last_tile, output ready);
endinterface

/* rtl/glw_ctrl.sv */
// Walk controller: idle/walk state machine issuing load and step commands.
`include "grid_line_tile_walker_defines.svh"
module glw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              tile_valid,
  input  logic              tile_ready,
  output glw_pkg::glw_cmd_t cmd,
  input  glw_pkg::glw_sts_t sts
);
  import glw_pkg::*;

  glw_state_t state;
  glw_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (tile_ready && sts.last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready  = 1'b0;
    tile_valid = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      ST_WALK: begin
        tile_valid = 1'b1;
        cmd.step   = tile_ready;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  `GLW_ASSERT(a_one_side_open, clk, rst, !(req_ready && tile_valid), "ready and valid overlap")
  `GLW_ASSERT(a_load_walks, clk, rst, cmd.load |=> (state == ST_WALK), "load did not start walk")
  `GLW_ASSERT(a_last_ends, clk, rst, (cmd.step && sts.last) |=> (state == ST_IDLE), "walk overran")

endmodule

/* rtl/glw_datapath.sv */
// Walk datapath: tile conversion, walk position, error term and tile count.
`include "grid_line_tile_walker_defines.svh"
module glw_datapath #(
  parameter int GRID_TILES = 32,
  parameter int TILE_SHIFT = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [glw_pkg::PX_W-1:0]   start_px_x,
  input  logic [glw_pkg::PX_W-1:0]   start_px_y,
  input  logic [glw_pkg::PX_W-1:0]   end_px_x,
  input  logic [glw_pkg::PX_W-1:0]   end_px_y,
  input  glw_pkg::glw_cmd_t          cmd,
  output glw_pkg::glw_sts_t          sts,
  output logic [glw_pkg::TILE_W-1:0] tile_x,
  output logic [glw_pkg::TILE_W-1:0] tile_y,
  output logic                       last_tile
);
  import glw_pkg::*;

  localparam logic [PX_W-1:0] MAX_TILE = PX_W'(GRID_TILES - 1);

  logic [TILE_W-1:0]       walk_x;
  logic [TILE_W-1:0]       walk_y;
  logic signed [ERR_W-1:0] step_error;
  logic [DBL_W-1:0]        double_dx;
  logic [DBL_W-1:0]        double_dy;
  logic [CNT_W-1:0]        tiles_left;
  logic                    x_backward;
  logic                    y_backward;

  logic [TILE_W-1:0] sx, sy, ex, ey;
  logic [TILE_W-1:0] adx, ady;
  logic              x_fwd, y_fwd;

  // Shift down to a tile index and clamp to the grid edge.
  function automatic logic [TILE_W-1:0] to_tile(input logic [PX_W-1:0] px);
    logic [PX_W-1:0] t;
    t = px >> TILE_SHIFT;
    if (t > MAX_TILE) begin
      t = MAX_TILE;
    end
    return t[TILE_W-1:0];
  endfunction

  always_comb begin
    sx    = to_tile(start_px_x);
    sy    = to_tile(start_px_y);
    ex    = to_tile(end_px_x);
    ey    = to_tile(end_px_y);
    x_fwd = ex > sx;
    y_fwd = ey > sy;
    adx   = x_fwd ? ex - sx : sx - ex;
    ady   = y_fwd ? ey - sy : sy - ey;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_x     <= '0;
      walk_y     <= '0;
      step_error <= '0;
      double_dx  <= '0;
      double_dy  <= '0;
      tiles_left <= '0;
      x_backward <= 1'b0;
      y_backward <= 1'b0;
    end else if (cmd.load) begin
      walk_x     <= sx;
      walk_y     <= sy;
      step_error <= signed'({2'b00, adx}) - signed'({2'b00, ady});
      double_dx  <= {adx, 1'b0};
      double_dy  <= {ady, 1'b0};
      tiles_left <= CNT_W'(1) + {1'b0, adx} + {1'b0, ady};
      x_backward <= !x_fwd;
      y_backward <= !y_fwd;
    end else if (cmd.step) begin
      // Positive error moves in x, zero or negative moves in y.
      if (step_error > 0) begin
        walk_x     <= x_backward ? walk_x - 1'b1 : walk_x + 1'b1;
        step_error <= step_error - signed'({1'b0, double_dy});
      end else begin
        walk_y     <= y_backward ? walk_y - 1'b1 : walk_y + 1'b1;
        step_error <= step_error + signed'({1'b0, double_dx});
      end
      tiles_left <= tiles_left - 1'b1;
    end
  end

  assign sts.last  = (tiles_left == CNT_W'(1));
  assign tile_x    = walk_x;
  assign tile_y    = walk_y;
  assign last_tile = sts.last;

  `GLW_ASSERT(a_step_has_tiles, clk, rst, cmd.step |-> (tiles_left != '0), "step with no tiles")
  `GLW_ASSERT(a_x_step_holds_y, clk, rst, (cmd.step && step_error > 0) |=> $stable(walk_y), "y moved on x step")
  `GLW_ASSERT(a_err_range, clk, rst, (step_error >= -62) && (step_error <= 62), "error term out of range")

endmodule

/* rtl/grid_line_tile_walker.sv */
// Top level of the grid line tile walker: controller plus datapath.
//
//   channel  dir  payload                                   handshake
//   -------  ---  ----------------------------------------  -----------
//   req      in   start_px_x/y, end_px_x/y (10 b each)      valid/ready
//   tile     out  tile_x, tile_y (5 b each), last_tile      valid/ready
//
// A request is taken only while no walk is running. The cycle after it is
// taken the first tile is shown, and each tile taken on the output advances
// the walk by one tile, so a request whose walk has N = 1+|dx|+|dy| tiles
// (1..63) holds the block until its last tile is taken. Without a stall, one
// tile per cycle comes from the single step of the error-term update loop.
// Reset (synchronous, active high) returns the controller to idle; a stall
// on the tile channel holds the current tile and freezes the walk.
module grid_line_tile_walker #(
  parameter int GRID_TILES = 32,
  parameter int TILE_SHIFT = 5
) (
  input  logic    clk,
  input  logic    rst,
  glw_req_if.sink   req,
  glw_tile_if.source tile
);
  import glw_pkg::*;

  glw_cmd_t cmd;
  glw_sts_t sts;

  // Sequence load, then one step per tile taken downstream.
  glw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .tile_valid (tile.valid),
    .tile_ready (tile.ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // Hold walk position, error term and count; drive the tile payload.
  glw_datapath #(
    .GRID_TILES (GRID_TILES),
    .TILE_SHIFT (TILE_SHIFT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .start_px_x (req.start_px_x),
    .start_px_y (req.start_px_y),
    .end_px_x   (req.end_px_x),
    .end_px_y   (req.end_px_y),
    .cmd        (cmd),
    .sts        (sts),
    .tile_x     (tile.tile_x),
    .tile_y     (tile.tile_y),
    .last_tile  (tile.last_tile)
  );

endmodule
